### design/csem_pkg.sv
// Shared constants for the counting semaphore table: command and status codes,
// field widths and parameter defaults.
// No dependencies.
package csem_pkg;

	// parameter defaults
	localparam int NUM_SEMAPHORES_DEF = 256;
	localparam int QUEUE_DEPTH_DEF    = 32;
	localparam int PID_BITS_DEF       = 16;
	localparam int COUNT_BITS_DEF     = 16;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int SEM_W    = 9;
	localparam int START_W  = 16;
	localparam int PIDF_W   = 16;
	localparam int STATUS_W = 3;
	localparam int MAXV_W   = 15;

	localparam logic [MAXV_W-1:0] MAX_VALUE_RST = 15'h7fff;

	// command codes
	localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
	localparam logic [OP_W-1:0] OP_WAIT   = 2'd1;
	localparam logic [OP_W-1:0] OP_POST   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_QUEUED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BADID  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOSLOT = 3'd4;

endpackage

### design/csem_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module csem_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port: data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/counting_semaphore_table_top.sv
// Counting semaphore table with a FIFO wait queue per semaphore.
// The result is registered once the entry memory has been read; a post that wakes a waiter
// first reads the queue memory as well. A new command is taken only once the last is done,
// as the entry memory is read then written and, on a wake, the queue memory is read too.
// Reset: control state is cleared, next free id returns to 1 and max_value returns to its full
// value at once; memories are not cleared, as slots are allocated in order and a nonzero id
// below the next free id is in use.
module counting_semaphore_table_top #(
	parameter int NUM_SEMAPHORES = csem_pkg::NUM_SEMAPHORES_DEF,
	parameter int QUEUE_DEPTH    = csem_pkg::QUEUE_DEPTH_DEF,
	parameter int PID_BITS       = csem_pkg::PID_BITS_DEF,
	parameter int COUNT_BITS     = csem_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [csem_pkg::MAXV_W-1:0]       cfg_data,
	// command channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [csem_pkg::OP_W-1:0]         operation,
	input  logic [csem_pkg::SEM_W-1:0]        sem_number,
	input  logic signed [csem_pkg::START_W-1:0] start_value,
	input  logic [csem_pkg::PIDF_W-1:0]       requester_pid,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [csem_pkg::STATUS_W-1:0]     status,
	output logic [csem_pkg::SEM_W-1:0]        new_id,
	output logic                              woke_valid,
	output logic [csem_pkg::PIDF_W-1:0]       woke_pid
);

	import csem_pkg::*;

	localparam int SIDX_W = $clog2(NUM_SEMAPHORES);
	localparam int NID_W  = $clog2(NUM_SEMAPHORES + 2);
	localparam int ID_W   = (SIDX_W > SEM_W) ? SIDX_W : SEM_W;
	localparam int CMP_W  = (NID_W > SEM_W) ? NID_W : SEM_W;
	localparam int QP_W   = $clog2(QUEUE_DEPTH);
	localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int QA_W   = $clog2(NUM_SEMAPHORES * QUEUE_DEPTH);
	localparam int EW     = COUNT_BITS + QC_W + QP_W;
	localparam int VW     = ((COUNT_BITS > MAXV_W) ? COUNT_BITS : MAXV_W) + 1;

	localparam logic [NID_W-1:0] NUM_N   = NID_W'(NUM_SEMAPHORES);
	localparam logic [QC_W-1:0]  QD_C    = QC_W'(QUEUE_DEPTH);
	localparam logic [QP_W-1:0]  QD_LAST = QP_W'(QUEUE_DEPTH - 1);
	localparam logic [QP_W:0]    QD_P    = (QP_W+1)'(QUEUE_DEPTH);
	localparam logic [VW-1:0]    TOP_V   = VW'((64'd1 << (COUNT_BITS - 1)) - 64'd1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_WAKE = 3'b100
	} state_t;

	state_t              state_q;
	logic [MAXV_W-1:0]   max_value_q;
	logic [NID_W-1:0]    next_free_q;

	logic [OP_W-1:0]     op_q;
	logic [SEM_W-1:0]    id_q;
	logic signed [START_W-1:0] start_q;
	logic [PIDF_W-1:0]   pid_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SEM_W-1:0]    new_id_q;
	logic                woke_valid_q;
	logic [PIDF_W-1:0]   woke_pid_q;

	logic                in_xfer;
	logic                out_free;
	logic [ID_W-1:0]     in_idx_full;
	logic [ID_W-1:0]     q_idx_full;
	logic [SIDX_W-1:0]   sidx;
	logic [SIDX_W-1:0]   create_idx;

	logic                ent_we;
	logic [SIDX_W-1:0]   ent_waddr;
	logic [EW-1:0]       ent_wdata;
	logic [EW-1:0]       ent_rdata;
	logic                q_we;
	logic                q_re;
	logic [QA_W-1:0]     q_addr;
	logic [PID_BITS-1:0] q_rdata;

	logic [COUNT_BITS-1:0] e_cnt;
	logic [QC_W-1:0]       e_n;
	logic [QP_W-1:0]       e_h;
	logic [QP_W:0]         tail_sum;
	logic [QP_W-1:0]       tail;
	logic [QP_W-1:0]       head_nxt;
	logic signed [VW-1:0]  v_ext;
	logic [VW-1:0]         ceil_v;
	logic                  id_ok;
	logic                  slot_free;

	logic                res_load;
	logic [STATUS_W-1:0] res_status;
	logic [SEM_W-1:0]    res_new_id;
	logic                res_woke;
	state_t              state_d;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// entry read address from the incoming command
	assign in_idx_full = ID_W'(sem_number) - ID_W'(1);
	assign q_idx_full  = ID_W'(id_q) - ID_W'(1);
	assign sidx        = q_idx_full[SIDX_W-1:0];
	assign create_idx  = SIDX_W'(next_free_q - NID_W'(1));

	// unpack the entry word
	assign e_cnt = ent_rdata[EW-1 -: COUNT_BITS];
	assign e_n   = ent_rdata[QP_W +: QC_W];
	assign e_h   = ent_rdata[QP_W-1:0];

	// queue positions, wrapped at the depth
	assign tail_sum = (QP_W+1)'(e_h) + (QP_W+1)'(e_n);
	assign tail     = (tail_sum >= QD_P) ? QP_W'(tail_sum - QD_P) : QP_W'(tail_sum);
	assign head_nxt = (e_h == QD_LAST) ? '0 : e_h + QP_W'(1);

	// count ceiling on post
	assign v_ext  = $signed({{(VW-COUNT_BITS){e_cnt[COUNT_BITS-1]}}, e_cnt});
	assign ceil_v = (VW'(max_value_q) < TOP_V) ? VW'(max_value_q) : TOP_V;

	// nonzero ids below the next free id are in use
	assign id_ok     = (id_q != '0) && (CMP_W'(id_q) < CMP_W'(next_free_q));
	assign slot_free = (next_free_q <= NUM_N);

	// execute the command against the entry just read
	always_comb begin
		state_d    = state_q;
		res_load   = 1'b0;
		res_status = ST_OK;
		res_new_id = '0;
		res_woke   = 1'b0;
		ent_we     = 1'b0;
		ent_waddr  = sidx;
		ent_wdata  = ent_rdata;
		q_we       = 1'b0;
		q_re       = 1'b0;
		q_addr     = QA_W'(sidx) * QA_W'(QUEUE_DEPTH) + QA_W'(e_h);
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (op_q == OP_CREATE) begin
					if (slot_free) begin
						res_new_id = SEM_W'(next_free_q);
						ent_waddr  = create_idx;
						ent_wdata  = {COUNT_BITS'(start_q), {QC_W{1'b0}}, {QP_W{1'b0}}};
						ent_we     = out_free;
					end else begin
						res_status = ST_NOSLOT;
					end
					res_load = out_free;
				end else if (op_q == OP_WAIT && id_ok) begin
					if (!e_cnt[COUNT_BITS-1] && (e_cnt != '0)) begin
						ent_wdata = {e_cnt - COUNT_BITS'(1), e_n, e_h};
						ent_we    = out_free;
					end else if (e_n < QD_C) begin
						res_status = ST_QUEUED;
						q_addr     = QA_W'(sidx) * QA_W'(QUEUE_DEPTH) + QA_W'(tail);
						q_we       = out_free;
						ent_wdata  = {e_cnt, e_n + QC_W'(1), e_h};
						ent_we     = out_free;
					end else begin
						res_status = ST_FULL;
					end
					res_load = out_free;
				end else if (op_q == OP_POST && id_ok) begin
					if (e_n != '0) begin
						q_re = 1'b1;
					end else begin
						if (v_ext < $signed(ceil_v)) begin
							ent_wdata = {e_cnt + COUNT_BITS'(1), e_n, e_h};
							ent_we    = out_free;
						end
						res_load = out_free;
					end
				end else begin
					res_status = ST_BADID;
					res_load   = out_free;
				end
				if (q_re) begin
					state_d = S_WAKE;
				end else if (res_load) begin
					state_d = S_IDLE;
				end
			end
			S_WAKE: begin
				res_woke  = 1'b1;
				ent_wdata = {e_cnt, e_n - QC_W'(1), head_nxt};
				ent_we    = out_free;
				res_load  = out_free;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			max_value_q <= MAX_VALUE_RST;
			next_free_q <= NID_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				max_value_q <= cfg_data;
			end
			if (state_q == S_EXEC && op_q == OP_CREATE && slot_free && out_free) begin
				next_free_q <= next_free_q + NID_W'(1);
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the accepted command
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= operation;
			id_q    <= sem_number;
			start_q <= start_value;
			pid_q   <= requester_pid;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q     <= res_status;
			new_id_q     <= res_new_id;
			woke_valid_q <= res_woke;
			woke_pid_q   <= res_woke ? PIDF_W'(q_rdata) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign new_id     = new_id_q;
	assign woke_valid = woke_valid_q;
	assign woke_pid   = woke_pid_q;

	// per-semaphore entry: count, waiter count, queue head
	csem_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_SEMAPHORES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (in_xfer),
		.raddr (in_idx_full[SIDX_W-1:0]),
		.rdata (ent_rdata)
	);

	// wait queues, one block of QUEUE_DEPTH pids per semaphore
	csem_ram #(
		.WIDTH (PID_BITS),
		.DEPTH (NUM_SEMAPHORES * QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_addr),
		.wdata (PID_BITS'(pid_q)),
		.re    (q_re),
		.raddr (q_addr),
		.rdata (q_rdata)
	);

endmodule
